// ===== hdl/lla_pkg.sv =====
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and constants of the life-like automaton generation block.
// ----------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

   // Default grid size
   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;

   // Field widths of the beats
   localparam int MODE_BITS  = 2;
   localparam int IDX_BITS   = 6;
   localparam int ROW_BITS   = 64;
   localparam int COUNT_BITS = 13;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 13'd8191;

   // Rule masks
   localparam int MASK_BITS = 9;
   localparam logic [MASK_BITS-1:0] BIRTH_RESET   = 9'd8;
   localparam logic [MASK_BITS-1:0] SURVIVE_RESET = 9'd12;

   // Register port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_BIRTH    = 4'h0,
      CSR_SURVIVE  = 4'h4,
      CSR_RIM_DEAD = 4'h8
   } csr_addr_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_READ    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_PREP,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Rule settings handed to the rule row
   typedef struct packed {
      logic [MASK_BITS-1:0] birth_mask;
      logic [MASK_BITS-1:0] survive_mask;
      logic                 rim_dead;
   } cfg_type;

   // Control from the sequencer to the tally
   typedef struct packed {
      logic clear;
      logic row_valid;
   } tally_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/lla_if.sv =====
// ----------------------------------------------------------------------------
// lla_if
// Request and response channels of the life-like automaton block.
// ----------------------------------------------------------------------------
`default_nettype none

interface lla_req_if;
   import lla_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [IDX_BITS-1:0]  row_index;
   logic [ROW_BITS-1:0]  row_cells;

   modport source (output valid, output mode, output row_index, output row_cells,
                   input ready);
   modport sink   (input valid, input mode, input row_index, input row_cells,
                   output ready);
endinterface

interface lla_rsp_if;
   import lla_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ROW_BITS-1:0]   row_bits;
   logic [COUNT_BITS-1:0] population;
   logic [COUNT_BITS-1:0] activity;

   modport source (output valid, output row_bits, output population, output activity,
                   input ready);
   modport sink   (input valid, input row_bits, input population, input activity,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/lla_row_cell.sv =====
// ----------------------------------------------------------------------------
// lla_row_cell
// One link of the row chain: holds one grid row and takes its neighbor's row
// on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_row_cell #(
   parameter int GRID_WIDTH = lla_pkg::DEF_GRID_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic [GRID_WIDTH-1:0] shift_in,
   output logic [GRID_WIDTH-1:0] row_out
);
   logic [GRID_WIDTH-1:0] row_ff;
   logic [GRID_WIDTH-1:0] row_in;

   // Take the neighbor's row on a shift, else hold
   assign row_in = shift_en ? shift_in : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

`default_nettype wire

// ===== hdl/lla_rule_row.sv =====
// ----------------------------------------------------------------------------
// lla_rule_row
// Next row of the grid from the rows above, at and below it: one neighbor
// count and mask lookup per column, with wrap at the sides.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_rule_row #(
   parameter int GRID_WIDTH = lla_pkg::DEF_GRID_WIDTH
) (
   input  lla_pkg::cfg_type       cfg,
   input  logic                   rim_row,
   input  logic [GRID_WIDTH-1:0]  up_row,
   input  logic [GRID_WIDTH-1:0]  mid_row,
   input  logic [GRID_WIDTH-1:0]  down_row,
   output logic [GRID_WIDTH-1:0]  next_row,
   output logic [GRID_WIDTH-1:0]  chg_row
);
   import lla_pkg::*;

   for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
      localparam int  LX   = (x == 0) ? GRID_WIDTH - 1 : x - 1;
      localparam int  RX   = (x == GRID_WIDTH - 1) ? 0 : x + 1;
      localparam bit  SIDE = (x == 0) || (x == GRID_WIDTH - 1);

      logic [3:0] n;
      logic       nv;
      logic       border;

      // Count the eight neighbors
      assign n = 4'(up_row[LX])   + 4'(up_row[x])   + 4'(up_row[RX])
               + 4'(mid_row[LX])                    + 4'(mid_row[RX])
               + 4'(down_row[LX]) + 4'(down_row[x]) + 4'(down_row[RX]);

      // Survive or birth by the cell's own state
      assign nv     = mid_row[x] ? cfg.survive_mask[n] : cfg.birth_mask[n];
      assign border = cfg.rim_dead && (rim_row || SIDE);

      // Hold border cells dead and leave them out of the change count
      assign next_row[x] = border ? 1'b0 : nv;
      assign chg_row[x]  = border ? 1'b0 : (nv ^ mid_row[x]);
   end

endmodule

`default_nettype wire

// ===== hdl/lla_tally.sv =====
// ----------------------------------------------------------------------------
// lla_tally
// Population and activity counters: registers each new row, counts its bits,
// then adds the counts into saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_tally #(
   parameter int GRID_WIDTH = lla_pkg::DEF_GRID_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lla_pkg::tally_ctl_type         ctl,
   input  logic [GRID_WIDTH-1:0]          next_row,
   input  logic [GRID_WIDTH-1:0]          chg_row,
   output logic                           busy,
   output logic [lla_pkg::COUNT_BITS-1:0] population,
   output logic [lla_pkg::COUNT_BITS-1:0] activity
);
   import lla_pkg::*;

   localparam int PC_BITS = $clog2(GRID_WIDTH + 1);

   function automatic logic [PC_BITS-1:0] bit_count(input logic [GRID_WIDTH-1:0] v);
      logic [PC_BITS-1:0] c;
      c = '0;
      for (int i = 0; i < GRID_WIDTH; i++) begin
         c = c + PC_BITS'(v[i]);
      end
      return c;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] acc,
                                                     input logic [PC_BITS-1:0]    inc);
      logic [COUNT_BITS:0] s;
      s = {1'b0, acc} + (COUNT_BITS + 1)'(inc);
      return (s > (COUNT_BITS + 1)'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   logic                  a_valid_ff;
   logic [GRID_WIDTH-1:0] a_next_ff;
   logic [GRID_WIDTH-1:0] a_chg_ff;
   logic                  b_valid_ff;
   logic [PC_BITS-1:0]    b_pop_ff;
   logic [PC_BITS-1:0]    b_act_ff;
   logic [COUNT_BITS-1:0] pop_ff;
   logic [COUNT_BITS-1:0] act_ff;
   logic [COUNT_BITS-1:0] pop_in;
   logic [COUNT_BITS-1:0] act_in;

   // Accumulate, or drop the totals at the start of a generation
   always_comb begin
      pop_in = pop_ff;
      act_in = act_ff;
      if (ctl.clear) begin
         pop_in = '0;
         act_in = '0;
      end else if (b_valid_ff) begin
         pop_in = sat_add(pop_ff, b_pop_ff);
         act_in = sat_add(act_ff, b_act_ff);
      end
   end

   // Control of the two stages and the totals
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         pop_ff     <= '0;
         act_ff     <= '0;
      end else begin
         a_valid_ff <= ctl.row_valid;
         b_valid_ff <= a_valid_ff;
         pop_ff     <= pop_in;
         act_ff     <= act_in;
      end
   end

   // Row and bit count stages
   always_ff @(posedge clock) begin
      if (ctl.row_valid) begin
         a_next_ff <= next_row;
         a_chg_ff  <= chg_row;
      end
      if (a_valid_ff) begin
         b_pop_ff <= bit_count(a_next_ff);
         b_act_ff <= bit_count(a_chg_ff);
      end
   end

   assign busy       = a_valid_ff | b_valid_ff;
   assign population = pop_ff;
   assign activity   = act_ff;

endmodule

`default_nettype wire

// ===== hdl/life_like_automaton_generation.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_generation
// Grid of one-bit cells held in a circular chain of row registers; writes,
// reads and birth/survival generations over the chain.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | beat
//  ---------+-----+---------------+-------------------------------------------
//  req_bus  | in  | valid/ready   | mode, row_index, row_cells
//  rsp_bus  | out | valid/ready   | row_bits, population, activity
//  csr_*    | in  | APB, no wait  | birth_mask 0x0, survive_mask 0x4,
//           |     |               | rim_dead 0x8
//
//  On a write or read the chain rotates one row a cycle until the addressed
//  row reaches the head.
//  In a generation one row a cycle passes through the rule row, then the
//  two tally stages drain.
//  One request is in work at a time; the response register holds a finished
//  beat while the next request is taken.
//  Reset clears every row at once and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_generation #(
   parameter int GRID_WIDTH  = lla_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = lla_pkg::DEF_GRID_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   lla_req_if.sink                           req_bus,
   lla_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lla_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lla_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lla_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import lla_pkg::*;

   localparam int IDX_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_HEIGHT - 1);

   // Registers
   logic [MASK_BITS-1:0]  birth_ff;
   logic [MASK_BITS-1:0]  survive_ff;
   logic                  rim_dead_ff;
   state_type             state_ff;
   state_type             state_in;
   logic [MODE_BITS-1:0]  mode_ff;
   logic [IDX_W-1:0]      target_ff;
   logic [GRID_WIDTH-1:0] data_ff;
   logic [GRID_WIDTH-1:0] pend_row_ff;
   logic [IDX_W-1:0]      head_idx_ff;
   logic [IDX_W-1:0]      step_ff;
   logic [GRID_WIDTH-1:0] first_ff;
   logic [GRID_WIDTH-1:0] prev_ff;
   logic                  rsp_valid_ff;
   logic [ROW_BITS-1:0]   rsp_row_ff;
   logic [COUNT_BITS-1:0] rsp_pop_ff;
   logic [COUNT_BITS-1:0] rsp_act_ff;

   // Chain and control
   logic [GRID_WIDTH-1:0] row_q    [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] chain_in [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] tail_in;
   logic                  shift_en;
   logic                  req_take;
   logic                  in_range;
   logic                  head_hit;
   logic                  read_capture;
   logic                  gen_prep;
   logic                  gen_sweep;
   logic                  rsp_load;
   logic                  out_free;
   logic                  cfg_write;
   cfg_type               cfg;
   tally_ctl_type         tally_ctl;
   logic                  tally_busy;
   logic [COUNT_BITS-1:0] tally_pop;
   logic [COUNT_BITS-1:0] tally_act;
   logic [GRID_WIDTH-1:0] down_row;
   logic                  rim_row;
   logic [GRID_WIDTH-1:0] rule_next;
   logic [GRID_WIDTH-1:0] rule_chg;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff    <= BIRTH_RESET;
         survive_ff  <= SURVIVE_RESET;
         rim_dead_ff <= 1'b0;
      end else if (cfg_write) begin
         case (csr_paddr)
            CSR_BIRTH:    birth_ff    <= csr_pwdata[MASK_BITS-1:0];
            CSR_SURVIVE:  survive_ff  <= csr_pwdata[MASK_BITS-1:0];
            CSR_RIM_DEAD: rim_dead_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         CSR_BIRTH:    csr_prdata = CSR_DATA_BITS'(birth_ff);
         CSR_SURVIVE:  csr_prdata = CSR_DATA_BITS'(survive_ff);
         CSR_RIM_DEAD: csr_prdata = CSR_DATA_BITS'(rim_dead_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.birth_mask   = birth_ff;
   assign cfg.survive_mask = survive_ff;
   assign cfg.rim_dead     = rim_dead_ff;

   // Request decode
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid & req_bus.ready;
   assign in_range      = {{(32 - IDX_BITS){1'b0}}, req_bus.row_index} < 32'(GRID_HEIGHT);
   assign head_hit      = (head_idx_ff == target_ff);
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;

   // Row chain
   for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_chain
      if (k == GRID_HEIGHT - 1) begin : g_tail
         assign chain_in[k] = tail_in;
      end else begin : g_link
         assign chain_in[k] = row_q[k + 1];
      end
      lla_row_cell #(
         .GRID_WIDTH (GRID_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (chain_in[k]),
         .row_out  (row_q[k])
      );
   end

   // Rule row on the head of the chain
   assign down_row = (step_ff == LAST_ROW) ? first_ff : row_q[1];
   assign rim_row  = (head_idx_ff == '0) || (head_idx_ff == LAST_ROW);

   lla_rule_row #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_rule (
      .cfg      (cfg),
      .rim_row  (rim_row),
      .up_row   (prev_ff),
      .mid_row  (row_q[0]),
      .down_row (down_row),
      .next_row (rule_next),
      .chg_row  (rule_chg)
   );

   assign tally_ctl.clear     = gen_prep;
   assign tally_ctl.row_valid = gen_sweep;

   lla_tally #(
      .GRID_WIDTH (GRID_WIDTH)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tally_ctl),
      .next_row   (rule_next),
      .chg_row    (rule_chg),
      .busy       (tally_busy),
      .population (tally_pop),
      .activity   (tally_act)
   );

   // Sequencer: next state and chain control
   always_comb begin
      state_in     = state_ff;
      shift_en     = 1'b0;
      tail_in      = row_q[0];
      read_capture = 1'b0;
      gen_prep     = 1'b0;
      gen_sweep    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_bus.mode)
                  MODE_WRITE, MODE_READ: state_in = in_range ? ST_SEEK : ST_DONE;
                  MODE_ADVANCE:          state_in = ST_PREP;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_SEEK: begin
            if (head_hit) begin
               if (mode_ff == MODE_WRITE) begin
                  shift_en = 1'b1;
                  tail_in  = data_ff;
               end else begin
                  read_capture = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               shift_en = 1'b1;
            end
         end
         ST_PREP: begin
            gen_prep = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            gen_sweep = 1'b1;
            shift_en  = 1'b1;
            tail_in   = rule_next;
            if (step_ff == LAST_ROW) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!tally_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (shift_en) begin
            head_idx_ff <= (head_idx_ff == LAST_ROW) ? '0 : head_idx_ff + IDX_W'(1);
         end
      end
   end

   // Hold the request and sweep context
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff     <= req_bus.mode;
         target_ff   <= IDX_W'({{(32 - IDX_BITS){1'b0}}, req_bus.row_index});
         data_ff     <= req_bus.row_cells[GRID_WIDTH-1:0];
         pend_row_ff <= '0;
      end else if (read_capture) begin
         pend_row_ff <= row_q[0];
      end
      if (gen_prep) begin
         first_ff <= row_q[0];
         prev_ff  <= row_q[GRID_HEIGHT - 1];
         step_ff  <= '0;
      end else if (gen_sweep) begin
         prev_ff <= row_q[0];
         step_ff <= step_ff + IDX_W'(1);
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff <= ROW_BITS'(pend_row_ff);
         rsp_pop_ff <= (mode_ff == MODE_ADVANCE) ? tally_pop : '0;
         rsp_act_ff <= (mode_ff == MODE_ADVANCE) ? tally_act : '0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.row_bits   = rsp_row_ff;
   assign rsp_bus.population = rsp_pop_ff;
   assign rsp_bus.activity   = rsp_act_ff;

endmodule

`default_nettype wire

// ===== hdl/lla_checker.sv =====
// ----------------------------------------------------------------------------
// lla_checker
// Port-level checks of the life-like automaton block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [lla_pkg::ROW_BITS-1:0]   row_bits,
   input  logic [lla_pkg::COUNT_BITS-1:0] population,
   input  logic [lla_pkg::COUNT_BITS-1:0] activity
);
   // No response beat right after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(row_bits)
                                 && $stable(population) && $stable(activity))
      else $error("stalled response beat changed");

   // One request in work at a time
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A read beat carries no counts
   a_read_no_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (row_bits != '0) |-> (population == '0) && (activity == '0))
      else $error("row data and counts in one beat");

endmodule

bind life_like_automaton_generation lla_checker u_lla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .row_bits   (rsp_bus.row_bits),
   .population (rsp_bus.population),
   .activity   (rsp_bus.activity)
);

`default_nettype wire
